// ----- rtl/abps_pkg.sv -----
// ----------------------------------------------------------------------------
// Alpha blend plane sample package
// Shared request, result and configuration types, register indexes and
// arithmetic constants, and the exact divide-by-255 helper.
// ----------------------------------------------------------------------------
package abps_pkg;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_GLOBAL_ALPHA     = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_CONSTANT_COLOUR  = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_WIDE_SAMPLES     = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_USE_SOURCE_PLANE = 8'd3;

    localparam logic [7:0]  GLOBAL_ALPHA_RESET    = 8'd255;
    localparam logic [7:0]  CONSTANT_COLOUR_RESET = 8'd0;

    localparam logic [15:0] ALPHA_FULL    = 16'd65025;
    localparam logic [31:0] BLEND_ROUND   = 32'd32512;
    localparam logic [23:0] SOURCE_ROUND  = 24'd127;
    localparam logic [31:0] DIV255_MAGIC  = 32'h8080_8081;
    localparam int          DIV255_SHIFT  = 39;

    typedef struct packed {
        logic [15:0] dst_sample;
        logic [15:0] src_sample;
        logic [7:0]  alpha;
        logic        last_in;
    } t_request;

    typedef struct packed {
        logic [15:0] blended_sample;
        logic        last_out;
    } t_result;

    typedef struct packed {
        logic [7:0] global_alpha;
        logic [7:0] constant_colour;
        logic       wide_samples;
        logic       use_source_plane;
    } t_cfg;

    typedef struct packed {
        logic        valid;
        logic        last;
        logic [31:0] numer;
        logic [15:0] src_term;
    } t_mix_stage;

    // Exact floor(x / 255) for any 32-bit x by reciprocal multiplication.
    function automatic logic [24:0] div255(input logic [31:0] x);
        logic [63:0] prod;
        prod = {32'd0, x} * {32'd0, DIV255_MAGIC};
        return prod[63:DIV255_SHIFT];
    endfunction

endpackage

// ----- rtl/abps_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Alpha blend configuration registers
// Holds global alpha, constant colour and the two mode bits, written through
// the configuration channel.
// ----------------------------------------------------------------------------
module abps_cfg_regs
    import abps_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output logic                   o_cfg_ready,
    output t_cfg                   o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_IDX_GLOBAL_ALPHA:     n_cfg.global_alpha     = i_cfg_data;
                CFG_IDX_CONSTANT_COLOUR:  n_cfg.constant_colour  = i_cfg_data;
                CFG_IDX_WIDE_SAMPLES:     n_cfg.wide_samples     = i_cfg_data[0];
                CFG_IDX_USE_SOURCE_PLANE: n_cfg.use_source_plane = i_cfg_data[0];
                default:                  n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.global_alpha     <= GLOBAL_ALPHA_RESET;
            r_cfg.constant_colour  <= CONSTANT_COLOUR_RESET;
            r_cfg.wide_samples     <= 1'b0;
            r_cfg.use_source_plane <= 1'b1;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

endmodule

// ----- rtl/abps_mix.sv -----
// ----------------------------------------------------------------------------
// Alpha blend product and sum stages
// Four pipeline stages that form the effective alpha, the weighted products
// and the 32-bit blend numerator, plus the rounded source term.
// ----------------------------------------------------------------------------
module abps_mix
    import abps_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_request   i_request,
    input  t_cfg       i_cfg,
    output t_mix_stage o_stage
);

    logic        r_s1_valid;
    logic        r_s1_last;
    logic [15:0] r_s1_dst;
    logic [15:0] r_s1_alpha;
    logic [23:0] r_s1_src;

    logic        r_s2_valid;
    logic        r_s2_last;
    logic [31:0] r_s2_dst;
    logic [23:0] r_s2_const;
    logic [15:0] r_s2_src;

    logic        r_s3_valid;
    logic        r_s3_last;
    logic [31:0] r_s3_dst;
    logic [31:0] r_s3_const;
    logic [15:0] r_s3_src;

    logic        r_s4_valid;
    logic        r_s4_last;
    logic [31:0] r_s4_numer;
    logic [15:0] r_s4_src;

    logic [15:0] n_dst;
    logic [15:0] n_src;
    logic [15:0] n_inv;
    logic [24:0] n_src_q;

    always_comb begin
        n_dst   = i_cfg.wide_samples ? i_request.dst_sample
                                     : {8'd0, i_request.dst_sample[7:0]};
        n_src   = i_cfg.wide_samples ? i_request.src_sample
                                     : {8'd0, i_request.src_sample[7:0]};
        n_inv   = ALPHA_FULL - r_s1_alpha;
        n_src_q = div255({8'd0, r_s1_src});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_last  <= i_request.last_in;
        r_s1_dst   <= n_dst;
        r_s1_alpha <= {8'd0, i_request.alpha} * {8'd0, i_cfg.global_alpha};
        r_s1_src   <= ({8'd0, n_src} * {16'd0, i_cfg.global_alpha}) + SOURCE_ROUND;

        r_s2_last  <= r_s1_last;
        r_s2_dst   <= {16'd0, r_s1_dst} * {16'd0, n_inv};
        r_s2_const <= {16'd0, i_cfg.constant_colour} * {8'd0, r_s1_alpha};
        r_s2_src   <= n_src_q[15:0];

        r_s3_last  <= r_s2_last;
        r_s3_dst   <= r_s2_dst + BLEND_ROUND;
        r_s3_const <= i_cfg.wide_samples
                      ? {8'd0, r_s2_const} * {24'd0, i_cfg.global_alpha}
                      : {8'd0, r_s2_const};
        r_s3_src   <= r_s2_src;

        r_s4_last  <= r_s3_last;
        r_s4_numer <= i_cfg.use_source_plane ? r_s3_dst : r_s3_dst + r_s3_const;
        r_s4_src   <= r_s3_src;
    end

    assign o_stage = {r_s4_valid, r_s4_last, r_s4_numer, r_s4_src};

endmodule

// ----- rtl/abps_div.sv -----
// ----------------------------------------------------------------------------
// Alpha blend divide and output stages
// Divides the blend numerator by 65025 as two exact divisions by 255, adds
// the source term in source plane mode, registering the sample-width result.
// ----------------------------------------------------------------------------
module abps_div
    import abps_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_mix_stage i_stage,
    input  t_cfg       i_cfg,
    output logic       o_strobe,
    output t_result    o_result
);

    logic        r_s5_valid;
    logic        r_s5_last;
    logic [24:0] r_s5_q;
    logic [15:0] r_s5_src;

    logic        r_s6_valid;
    logic        r_s6_last;
    logic [16:0] r_s6_q;
    logic [15:0] r_s6_src;

    logic        r_strobe;
    t_result     r_result;

    logic [24:0] n_q6;
    logic [16:0] n_sum;

    always_comb begin
        n_q6  = div255({7'd0, r_s5_q});
        n_sum = i_cfg.use_source_plane ? r_s6_q + {1'b0, r_s6_src} : r_s6_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_valid <= 1'b0;
            r_s6_valid <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_s5_valid <= i_stage.valid;
            r_s6_valid <= r_s5_valid;
            r_strobe   <= r_s6_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s5_last <= i_stage.last;
        r_s5_q    <= div255(i_stage.numer);
        r_s5_src  <= i_stage.src_term;

        r_s6_last <= r_s5_last;
        r_s6_q    <= n_q6[16:0];
        r_s6_src  <= r_s5_src;

        r_result.last_out       <= r_s6_last;
        r_result.blended_sample <= i_cfg.wide_samples ? n_sum[15:0]
                                                      : {8'd0, n_sum[7:0]};
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// ----- rtl/alpha_blend_plane_sample_core.sv -----
// ----------------------------------------------------------------------------
// Alpha blend plane sample core
// Premultiplied-alpha over blend of one plane sample per request.
//
// A request (destination sample, source sample, alpha, last flag) is taken
// at a rising edge with start high and busy low. Busy stays low, so a new
// request may be issued in every cycle.
// Each request gives one result on o_result, marked by o_strobe for a single
// cycle, and results leave in request order.
// Sustained rate is one request per clock; the path runs through the seven
// register stages (products, numerator sum, two divide-by-255 multiplies,
// final add).
// The receiver cannot hold results off, so nothing in the pipeline ever
// waits. Configuration is written on its own valid/ready channel and must
// only change while no request is in flight.
// A synchronous reset restores the register defaults and drops all requests
// in flight; no strobe is given until new requests arrive.
// ----------------------------------------------------------------------------
module alpha_blend_plane_sample_core
    import abps_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  t_request               i_request,
    output logic                   o_strobe,
    output t_result                o_result,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cfg       cfg;
    t_mix_stage mix_stage;
    logic       cfg_ready;

    assign busy = 1'b0;

    abps_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid & cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (cfg_ready),
        .o_cfg       (cfg)
    );

    assign o_cfg_ready = cfg_ready;

    abps_mix u_mix (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (start & ~busy),
        .i_request (i_request),
        .i_cfg     (cfg),
        .o_stage   (mix_stage)
    );

    abps_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_stage  (mix_stage),
        .i_cfg    (cfg),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

// ----- rtl/abps_checker.sv -----
// ----------------------------------------------------------------------------
// Alpha blend port checker
// Checks the fixed latency and ordering of results seen at the top level
// ports, and that no strobe follows reset.
// ----------------------------------------------------------------------------
module abps_checker
    import abps_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  logic     busy,
    input  t_request i_request,
    input  logic     o_strobe,
    input  t_result  o_result
);

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##7 o_strobe)
        else $error("accepted request gave no result after seven cycles");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, 7))
        else $error("result strobe without a matching request");

    a_last_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.last_out == $past(i_request.last_in, 7)))
        else $error("last flag does not match its request");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("result strobe right after reset");

endmodule

bind alpha_blend_plane_sample_core abps_checker u_abps_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .start     (start),
    .busy      (busy),
    .i_request (i_request),
    .o_strobe  (o_strobe),
    .o_result  (o_result)
);
